// ===== design/kalman_cv_2d_tracker_unit_assert.svh =====
// ---------------------------------------------------------------------------
// kalman_cv_2d_tracker_unit_assert.svh
// Assertion macros used by the tracker unit, clocked on clk, off in reset
// ---------------------------------------------------------------------------
`ifndef KALMAN_CV_2D_TRACKER_UNIT_ASSERT_SVH
`define KALMAN_CV_2D_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define KCVT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KCVT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kcvt_pkg.sv =====
// ---------------------------------------------------------------------------
// kcvt_pkg
// Shared types and constants of the constant-velocity 2d tracker
// ---------------------------------------------------------------------------
package kcvt_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // commands
  localparam logic [1:0] CMD_PREDICT = 2'd0;
  localparam logic [1:0] CMD_UPDATE  = 2'd1;
  localparam logic [1:0] CMD_SET     = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_PROC_NOISE = 2'd0;
  localparam logic [1:0] REG_SENS_NOISE = 2'd1;
  localparam logic [1:0] REG_SET_UNC    = 2'd3;

  // reset values, unsigned q16.16
  localparam logic [31:0] PROC_NOISE_RST = 32'd655;
  localparam logic [31:0] SENS_NOISE_RST = 32'd6554;
  localparam logic [30:0] INIT_UNC_RST   = 31'd65536000;
  localparam logic [30:0] SET_UNC_RST    = 31'd6554;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [19:0]        dt;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic               singular;
  } out_t;

endpackage

// ===== design/kalman_cv_2d_tracker_unit.sv =====
// Update: a zero determinant skips the four divides and ends the update as singular;
//   a covariance term is a memory read plus a multiply.
// Throughput: one request at a time, set by the multiply-accumulate loop over the
//   covariance memory (one read port, one write port) and the bit-serial divider.
// Reset: synchronous, active low; state vector zero, covariance reads as the reset
// ---------------------------------------------------------------------------
// kalman_cv_2d_tracker_unit
// Constant-velocity 2d kalman tracker with covariance held in a banked memory
// ---------------------------------------------------------------------------
module kalman_cv_2d_tracker_unit #(
  parameter int DATA_WIDTH = kcvt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = kcvt_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  kcvt_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output kcvt_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  localparam int W = DATA_WIDTH;
  localparam int F = FRAC_BITS;
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [63:0] VMAX64 = (64'd1 << (W - 1)) - 64'd1;
  localparam logic signed [63:0] VMAX64S = signed'(VMAX64);
  localparam logic signed [63:0] VMIN64S = -VMAX64S - 64'sd1;
  localparam logic [W-1:0] ONE = (F >= W - 1) ? VMAX : W'(64'd1 << F);
  localparam logic [W-1:0] INIT_DIAG =
    (64'(kcvt_pkg::INIT_UNC_RST) > VMAX64) ? VMAX : W'(kcvt_pkg::INIT_UNC_RST);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SC_GO  = 4'd1;
  localparam logic [3:0] ST_SC_WT  = 4'd2;
  localparam logic [3:0] ST_DV_GO  = 4'd3;
  localparam logic [3:0] ST_DV_WT  = 4'd4;
  localparam logic [3:0] ST_MM_RD  = 4'd5;
  localparam logic [3:0] ST_MM_GO  = 4'd6;
  localparam logic [3:0] ST_MM_WT  = 4'd7;
  localparam logic [3:0] ST_DG_RD  = 4'd8;
  localparam logic [3:0] ST_DG_WR  = 4'd9;
  localparam logic [3:0] ST_SET_WR = 4'd10;
  localparam logic [3:0] ST_LD_RD  = 4'd11;
  localparam logic [3:0] ST_LD_CAP = 4'd12;
  localparam logic [3:0] ST_FIN    = 4'd13;

  localparam logic [1:0] MM_FP  = 2'd0;
  localparam logic [1:0] MM_PFT = 2'd1;
  localparam logic [1:0] MM_MP  = 2'd2;

  function automatic logic [W-1:0] sadd_f(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) sadd_f = s[W] ? VMIN : VMAX;
    else sadd_f = s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sneg_f(input logic [W-1:0] x);
    sneg_f = (x == VMIN) ? VMAX : (~x + W'(1));
  endfunction

  function automatic logic [W-1:0] ssub_f(input logic [W-1:0] x, input logic [W-1:0] y);
    ssub_f = sadd_f(x, sneg_f(y));
  endfunction

  function automatic logic [W-1:0] satu_f(input logic [31:0] v);
    satu_f = (64'(v) > VMAX64) ? VMAX : W'(v);
  endfunction

  function automatic logic [W-1:0] sats_f(input logic [31:0] v);
    logic signed [63:0] e;
    e = 64'(signed'(v));
    if (e > VMAX64S) sats_f = VMAX;
    else if (e < VMIN64S) sats_f = VMIN;
    else sats_f = e[W-1:0];
  endfunction

  function automatic logic [31:0] to32_f(input logic [W-1:0] v);
    logic signed [63:0] e;
    e = 64'(signed'(v));
    if (e > 64'sd2147483647) to32_f = 32'h7fffffff;
    else if (e < -64'sd2147483648) to32_f = 32'h80000000;
    else to32_f = e[31:0];
  endfunction

  // covariance: two banks of 16, the live one picked by cur_r
  logic [W-1:0] mem [32];
  logic [31:0]  valid_r;
  logic [W-1:0] rd_q_r;
  logic         rd_vld_r;
  logic [4:0]   rd_addr_r;
  logic         cur_r;

  logic [3:0]   st_r;
  logic [1:0]   cmd_r;
  logic [1:0]   kind_r;
  logic [4:0]   step_r;
  logic [3:0]   e_r, n_r;
  logic [1:0]   kk_r, dv_r;
  logic         sing_r, out_valid_r;
  kcvt_pkg::out_t out_r;

  logic [31:0]  pn_r, sn_r;
  logic [30:0]  su_r;

  logic [W-1:0] x_r [4];
  logic [W-1:0] gain_r [8];
  logic [W-1:0] pc_r [8];
  logic [W-1:0] inv_r [4];
  logic [W-1:0] innov_r [2];
  logic [W-1:0] acc_r, det_r, dtv_r;

  logic         mul_start, mul_done, div_start, div_done;
  logic [W-1:0] mul_a, mul_b, mul_res, div_num, div_res;
  logic [4:0]   rd_addr, wr_addr;
  logic         wr_en;
  logic [W-1:0] wr_data, rdata, gen_v, sc_a, sc_b;
  logic [W-1:0] s00, s01, s10, s11, rv, qv, suv, mm_sum, det_new;
  logic [3:0]   un;
  logic [2:0]   xn;
  logic [1:0]   ie, je;
  logic         in_acc, cfg_acc, out_free;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (st_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    rdata   = rd_vld_r ? rd_q_r :
              ((rd_addr_r[3:2] == rd_addr_r[1:0]) ? INIT_DIAG : '0);
    rv      = satu_f(sn_r);
    qv      = satu_f(pn_r);
    suv     = satu_f({1'b0, su_r});
    s00     = sadd_f(pc_r[0], rv);
    s01     = pc_r[1];
    s10     = pc_r[2];
    s11     = sadd_f(pc_r[3], rv);
    un      = 4'(step_r - 5'd2);
    xn      = 3'(step_r - 5'd18);
    ie      = e_r[3:2];
    je      = e_r[1:0];
    mm_sum  = sadd_f(acc_r, mul_res);
    det_new = ssub_f(acc_r, mul_res);

    // element of F, F transposed or I - K H for the running product
    gen_v = '0;
    case (kind_r)
      MM_FP: begin
        if (ie == kk_r) gen_v = ONE;
        else if ((ie == 2'd0 && kk_r == 2'd2) || (ie == 2'd1 && kk_r == 2'd3)) gen_v = dtv_r;
      end
      MM_PFT: begin
        if (je == kk_r) gen_v = ONE;
        else if ((je == 2'd0 && kk_r == 2'd2) || (je == 2'd1 && kk_r == 2'd3)) gen_v = dtv_r;
      end
      default: begin
        if (!kk_r[1]) gen_v = ssub_f((ie == kk_r) ? ONE : '0, gain_r[{ie, kk_r[0]}]);
        else gen_v = (ie == kk_r) ? ONE : '0;
      end
    endcase

    sc_a = ONE;
    sc_b = x_r[3];
    if (cmd_r == kcvt_pkg::CMD_PREDICT) begin
      case (step_r)
        5'd0: sc_b = x_r[0];
        5'd1: begin sc_a = dtv_r; sc_b = x_r[2]; end
        5'd2: sc_b = x_r[1];
        5'd3: begin sc_a = dtv_r; sc_b = x_r[3]; end
        5'd4: sc_b = x_r[2];
        default: sc_b = x_r[3];
      endcase
    end else if (step_r == 5'd0) begin
      sc_a = s00;
      sc_b = s11;
    end else if (step_r == 5'd1) begin
      sc_a = s01;
      sc_b = s10;
    end else if (step_r < 5'd18) begin
      sc_a = pc_r[{un[3:2], un[0]}];
      sc_b = inv_r[{un[0], un[1]}];
    end else begin
      sc_a = gain_r[{xn[2:1], xn[0]}];
      sc_b = innov_r[xn[0]];
    end

    mul_start = (st_r == ST_SC_GO) || (st_r == ST_MM_GO);
    mul_a     = (st_r == ST_MM_GO) ? gen_v : sc_a;
    mul_b     = (st_r == ST_MM_GO) ? rdata : sc_b;

    div_start = (st_r == ST_DV_GO);
    case (dv_r)
      2'd0:    div_num = s11;
      2'd1:    div_num = sneg_f(s01);
      2'd2:    div_num = sneg_f(s10);
      default: div_num = s00;
    endcase

    case (st_r)
      ST_DG_RD: rd_addr = {cur_r, n_r[1:0], n_r[1:0]};
      ST_LD_RD: rd_addr = {cur_r, n_r[2:1], 1'b0, n_r[0]};
      default:  rd_addr = (kind_r == MM_PFT) ? {cur_r, ie, kk_r} : {cur_r, kk_r, je};
    endcase

    wr_en   = 1'b0;
    wr_addr = {!cur_r, e_r};
    wr_data = mm_sum;
    case (st_r)
      ST_MM_WT: wr_en = mul_done && (kk_r == 2'd3);
      ST_DG_WR: begin
        wr_en   = 1'b1;
        wr_addr = {cur_r, n_r[1:0], n_r[1:0]};
        wr_data = sadd_f(rdata, qv);
      end
      ST_SET_WR: begin
        wr_en   = 1'b1;
        wr_addr = {cur_r, n_r};
        wr_data = (n_r[3:2] == n_r[1:0]) ? suv : '0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r    <= mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  kcvt_mul #(.W(W), .F(F)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  kcvt_div #(.W(W), .F(F)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (det_r),
    .done  (div_done),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cmd_r       <= kcvt_pkg::CMD_NOP;
      kind_r      <= MM_FP;
      step_r      <= '0;
      e_r         <= '0;
      n_r         <= '0;
      kk_r        <= '0;
      dv_r        <= '0;
      sing_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cur_r       <= 1'b0;
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      pn_r        <= kcvt_pkg::PROC_NOISE_RST;
      sn_r        <= kcvt_pkg::SENS_NOISE_RST;
      su_r        <= kcvt_pkg::SET_UNC_RST;
      for (int i = 0; i < 4; i++) x_r[i] <= '0;
    end else begin
      rd_vld_r <= valid_r[rd_addr];
      if (wr_en) valid_r[wr_addr] <= 1'b1;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      if (cfg_acc) begin
        case (cfg_index)
          kcvt_pkg::REG_PROC_NOISE: pn_r <= cfg_data;
          kcvt_pkg::REG_SENS_NOISE: sn_r <= cfg_data;
          kcvt_pkg::REG_SET_UNC:    su_r <= cfg_data[30:0];
          // initial uncertainty only shapes the reset covariance
          default: ;
        endcase
      end

      case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r      <= in_data.cmd;
            dtv_r      <= satu_f({12'd0, in_data.dt});
            sing_r     <= 1'b0;
            step_r     <= '0;
            n_r        <= '0;
            innov_r[0] <= ssub_f(sats_f(in_data.pos_x), x_r[0]);
            innov_r[1] <= ssub_f(sats_f(in_data.pos_y), x_r[1]);
            case (in_data.cmd)
              kcvt_pkg::CMD_PREDICT: st_r <= ST_SC_GO;
              kcvt_pkg::CMD_UPDATE:  st_r <= ST_LD_RD;
              kcvt_pkg::CMD_SET: begin
                x_r[0] <= sats_f(in_data.pos_x);
                x_r[1] <= sats_f(in_data.pos_y);
                x_r[2] <= sats_f(in_data.vel_x);
                x_r[3] <= sats_f(in_data.vel_y);
                st_r   <= ST_SET_WR;
              end
              default: st_r <= ST_FIN;
            endcase
          end
        end
        ST_SC_GO: st_r <= ST_SC_WT;
        ST_SC_WT: begin
          if (mul_done) begin
            st_r   <= ST_SC_GO;
            step_r <= step_r + 5'd1;
            if (cmd_r == kcvt_pkg::CMD_PREDICT) begin
              case (step_r)
                5'd1: x_r[0] <= mm_sum;
                5'd3: x_r[1] <= mm_sum;
                5'd4: x_r[2] <= mul_res;
                5'd5: x_r[3] <= mul_res;
                default: acc_r <= mul_res;
              endcase
              if (step_r == 5'd5) begin
                kind_r <= MM_FP;
                e_r    <= '0;
                kk_r   <= '0;
                acc_r  <= '0;
                st_r   <= ST_MM_RD;
              end
            end else if (step_r == 5'd0) begin
              acc_r <= mul_res;
            end else if (step_r == 5'd1) begin
              det_r <= det_new;
              dv_r  <= '0;
              if (det_new == '0) begin
                sing_r <= 1'b1;
                st_r   <= ST_FIN;
              end else begin
                st_r <= ST_DV_GO;
              end
            end else if (step_r < 5'd18) begin
              if (!un[0]) acc_r <= mul_res;
              else gain_r[un[3:1]] <= mm_sum;
            end else begin
              if (!xn[0]) acc_r <= mul_res;
              else x_r[xn[2:1]] <= sadd_f(x_r[xn[2:1]], mm_sum);
              if (step_r == 5'd25) begin
                kind_r <= MM_MP;
                e_r    <= '0;
                kk_r   <= '0;
                acc_r  <= '0;
                st_r   <= ST_MM_RD;
              end
            end
          end
        end
        ST_DV_GO: st_r <= ST_DV_WT;
        ST_DV_WT: begin
          if (div_done) begin
            inv_r[dv_r] <= div_res;
            dv_r        <= dv_r + 2'd1;
            if (dv_r == 2'd3) begin
              step_r <= 5'd2;
              st_r   <= ST_SC_GO;
            end else begin
              st_r <= ST_DV_GO;
            end
          end
        end
        ST_MM_RD: st_r <= ST_MM_GO;
        ST_MM_GO: st_r <= ST_MM_WT;
        ST_MM_WT: begin
          if (mul_done) begin
            st_r <= ST_MM_RD;
            kk_r <= kk_r + 2'd1;
            if (kk_r == 2'd3) begin
              acc_r <= '0;
              e_r   <= e_r + 4'd1;
              if (e_r == 4'd15) begin
                // result bank becomes the live covariance
                cur_r <= !cur_r;
                n_r   <= '0;
                case (kind_r)
                  MM_FP:   kind_r <= MM_PFT;
                  MM_PFT:  st_r <= ST_DG_RD;
                  default: st_r <= ST_FIN;
                endcase
              end
            end else begin
              acc_r <= mm_sum;
            end
          end
        end
        ST_DG_RD: st_r <= ST_DG_WR;
        ST_DG_WR: begin
          n_r  <= n_r + 4'd1;
          st_r <= (n_r == 4'd3) ? ST_FIN : ST_DG_RD;
        end
        ST_SET_WR: begin
          n_r <= n_r + 4'd1;
          if (n_r == 4'd15) st_r <= ST_FIN;
        end
        ST_LD_RD: st_r <= ST_LD_CAP;
        ST_LD_CAP: begin
          pc_r[n_r[2:0]] <= rdata;
          n_r            <= n_r + 4'd1;
          st_r           <= (n_r == 4'd7) ? ST_SC_GO : ST_LD_RD;
        end
        ST_FIN: begin
          if (out_free) begin
            out_r.est_x    <= to32_f(x_r[0]);
            out_r.est_y    <= to32_f(x_r[1]);
            out_r.singular <= sing_r;
            out_valid_r    <= 1'b1;
            st_r           <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

`include "kalman_cv_2d_tracker_unit_assert.svh"

  `KCVT_ASSERT_NEXT(a_accept_busy, in_acc, st_r != ST_IDLE, "request accepted but sequencer idle")
  `KCVT_ASSERT_NEXT(a_fin_result, st_r == ST_FIN && out_free, out_valid_r, "finished step gave no result")
  `KCVT_ASSERT_IMPL(a_sing_update, sing_r, cmd_r == kcvt_pkg::CMD_UPDATE, "singular flag outside update")
  `KCVT_ASSERT_IMPL(a_mm_bank, st_r == ST_MM_WT && wr_en, wr_addr[4] != cur_r, "product written to live bank")

endmodule

// ===== design/kcvt_mul.sv =====
// ---------------------------------------------------------------------------
// kcvt_mul
// Saturating fixed-point multiplier, four half-width partial products
// ---------------------------------------------------------------------------
module kcvt_mul #(
  parameter int W = kcvt_pkg::DATA_WIDTH_DEF,
  parameter int F = kcvt_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] res
);

  localparam int H  = (W + 1) / 2;
  localparam int H2 = 2 * H;
  localparam int AW = 4 * H;
  localparam logic [AW:0] HALF  = (AW+1)'(1) << (F - 1);
  localparam logic [AW:0] BND_N = (AW+1)'(1) << (W - 1);
  localparam logic [AW:0] BND_P = BND_N - (AW+1)'(1);
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic [H2-1:0] ma_r, mb_r;
  logic          neg_r;
  logic [AW-1:0] acc_r;
  logic [2:0]    cnt_r;
  logic          busy_r, done_r;
  logic [W-1:0]  res_r;

  logic [H-1:0]  pa, pb;
  logic [H2-1:0] pp;
  logic [AW-1:0] pp_sh;
  logic [AW:0]   rnd, mq;
  logic [W-1:0]  ma_in, mb_in;

  always_comb begin
    ma_in = a[W-1] ? (~a + W'(1)) : a;
    mb_in = b[W-1] ? (~b + W'(1)) : b;
    pa    = cnt_r[1] ? ma_r[H2-1:H] : ma_r[H-1:0];
    pb    = cnt_r[0] ? mb_r[H2-1:H] : mb_r[H-1:0];
    pp    = H2'(pa) * H2'(pb);
    case (cnt_r[1:0])
      2'd0:    pp_sh = AW'(pp);
      2'd3:    pp_sh = AW'(pp) << H2;
      default: pp_sh = AW'(pp) << H;
    endcase
    rnd = {1'b0, acc_r} + HALF;
    mq  = rnd >> F;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ma_r   <= H2'(ma_in);
        mb_r   <= H2'(mb_in);
        neg_r  <= a[W-1] ^ b[W-1];
        acc_r  <= '0;
        cnt_r  <= 3'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!cnt_r[2]) begin
          acc_r <= acc_r + pp_sh;
          cnt_r <= cnt_r + 3'd1;
        end else begin
          // round, drop fraction, saturate
          if (neg_r) begin
            res_r <= (mq > BND_N) ? VMIN : (~mq[W-1:0] + W'(1));
          end else begin
            res_r <= (mq > BND_P) ? VMAX : mq[W-1:0];
          end
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== design/kcvt_div.sv =====
// ---------------------------------------------------------------------------
// kcvt_div
// Saturating fixed-point divider, restoring, one quotient bit per cycle
// ---------------------------------------------------------------------------
module kcvt_div #(
  parameter int W = kcvt_pkg::DATA_WIDTH_DEF,
  parameter int F = kcvt_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] res
);

  localparam int NB = W + F;
  localparam int CW = $clog2(NB + 1);
  localparam logic [NB-1:0] BND_N = NB'(1) << (W - 1);
  localparam logic [NB-1:0] BND_P = BND_N - NB'(1);
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic [NB-1:0] num_r, q_r;
  logic [W-1:0]  rem_r, den_r, res_r;
  logic          neg_r, busy_r, done_r;
  logic [CW-1:0] cnt_r;

  logic [W:0]   rs, rsub;
  logic         ge;
  logic [W-1:0] mn, md;

  always_comb begin
    mn   = num[W-1] ? (~num + W'(1)) : num;
    md   = den[W-1] ? (~den + W'(1)) : den;
    rs   = {rem_r, num_r[NB-1]};
    ge   = rs >= {1'b0, den_r};
    rsub = rs - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= {mn, {F{1'b0}}};
        den_r  <= md;
        neg_r  <= num[W-1] ^ den[W-1];
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r != CW'(NB)) begin
          rem_r <= ge ? rsub[W-1:0] : rs[W-1:0];
          num_r <= num_r << 1;
          q_r   <= {q_r[NB-2:0], ge};
          cnt_r <= cnt_r + CW'(1);
        end else begin
          if (neg_r) begin
            res_r <= (q_r > BND_N) ? VMIN : (~q_r[W-1:0] + W'(1));
          end else begin
            res_r <= (q_r > BND_P) ? VMAX : q_r[W-1:0];
          end
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
